// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the page-frame manager RTL.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property, checked on every rising clock edge outside reset.
`define CHK_ALWAYS(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/lrupfm_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and codes for the LRU page-frame manager.
// No dependencies.
package lrupfm_pkg;

  localparam logic [1:0] ACT_GET = 2'd0;
  localparam logic [1:0] ACT_PUT = 2'd1;
  localparam logic [1:0] ACT_DEL = 2'd2;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_SCAN = 6'b000010,
    S_POP  = 6'b000100,
    S_POPW = 6'b001000,
    S_FILL = 6'b010000,
    S_UPD  = 6'b100000
  } state_t;

  // rank pass flavors
  typedef enum logic [1:0] {
    UPD_INC_LT  = 2'd0,   // hit: frames more recent than the hit frame age by one
    UPD_DEC_GT  = 2'd1,   // delete: frames older than the freed one move up
    UPD_INC_ALL = 2'd2    // fill: every other valid frame ages by one
  } upd_mode_t;

endpackage

// ===== rtl/lrupfm_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the page-frame manager: request and result.
// No dependencies.
interface lrupfm_req_if #(
  parameter int KEY_BITS = 32
);
  logic                valid;
  logic                ready;
  logic [1:0]          action;
  logic [KEY_BITS-1:0] page_key;

  modport source (output valid, action, page_key, input ready);
  modport sink   (input valid, action, page_key, output ready);
endinterface

interface lrupfm_rsp_if #(
  parameter int FRAME_BITS = 4,
  parameter int KEY_BITS   = 32
);
  logic                  valid;
  logic                  ready;
  logic                  hit;
  logic [FRAME_BITS-1:0] frame;
  logic                  fetch;
  logic                  evicted;
  logic [KEY_BITS-1:0]   evicted_key;
  logic                  write_back;

  modport source (output valid, hit, frame, fetch, evicted, evicted_key, write_back,
                  input ready);
  modport sink   (input valid, hit, frame, fetch, evicted, evicted_key, write_back,
                  output ready);
endinterface

// ===== rtl/lrupfm_ram.sv =====
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lrupfm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/lru_page_frame_manager_unit.sv =====
`timescale 1ns / 1ps
// LRU page-frame manager top level: sequencer, frame tables and result register.
// Depends on lrupfm_pkg, lrupfm_if, lrupfm_ram and assert_macros.svh.
//
// Usage:
//   req (sink): one transaction per get / put / delete of a page key.
//   rsp (source): exactly one result transaction per request.
//   A request is taken only while the sequencer is idle. A single counter walks
//   the frames through the key and rank RAMs, one frame per cycle: a search pass
//   finds the key and the least recently used frame, then a rank pass rewrites
//   the recency ranks. A miss adds a key write, and before it a free-stack pop
//   when a free frame is left. A delete miss skips the rank pass, and an unused
//   action code skips both passes. The next request is taken in the cycle after
//   the result is registered. One request at a time.
//   The result sits in an output register, so a new request is taken while a
//   result waits; if rsp stalls, the next result waits in the sequencer.
//   Reset (rst, synchronous): all frames invalid, the free stack holds every
//   frame with frame 0 on top, no result pending. No clearing pass is needed.
`include "assert_macros.svh"
module lru_page_frame_manager_unit #(
  parameter int ENTRIES  = 16,
  parameter int KEY_BITS = 32
) (
  input  logic         clk,
  input  logic         rst,
  lrupfm_req_if.sink   req,
  lrupfm_rsp_if.source rsp
);

  localparam int FB = $clog2(ENTRIES);
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] CNT_END  = CW'(ENTRIES);
  localparam logic [FB-1:0] TOP_IDX  = FB'(ENTRIES - 1);

  lrupfm_pkg::state_t    state;
  lrupfm_pkg::upd_mode_t mode;

  logic [CW-1:0]       cnt;
  logic                rd_vld;
  logic [FB-1:0]       rd_idx;
  logic [1:0]          act;
  logic [KEY_BITS-1:0] key_q;

  logic                found;
  logic [FB-1:0]       fidx;
  logic [FB-1:0]       frank;
  logic                any_v;
  logic [FB-1:0]       lru_idx;
  logic [FB-1:0]       lru_rank;
  logic [KEY_BITS-1:0] lru_key;
  logic [FB-1:0]       ref_rank;

  logic [ENTRIES-1:0]  valid;
  logic [ENTRIES-1:0]  dirty;
  logic [ENTRIES-1:0]  stk_wr;
  logic [CW-1:0]       free_count;
  logic [FB-1:0]       pop_pos;

  logic [FB-1:0]       fsel;
  logic                r_hit;
  logic                r_fetch;
  logic                r_ev;
  logic [KEY_BITS-1:0] r_ekey;
  logic                r_wb;

  logic                out_vld;
  logic                out_hit;
  logic [FB-1:0]       out_frame;
  logic                out_fetch;
  logic                out_ev;
  logic [KEY_BITS-1:0] out_ekey;
  logic                out_wb;

  // RAM ports
  logic [KEY_BITS-1:0] key_rd;
  logic [FB-1:0]       rank_rd;
  logic [FB-1:0]       stk_rd;
  logic                key_we;
  logic                rank_we;
  logic [FB-1:0]       rank_wdata;
  logic                stk_we;
  logic [FB-1:0]       stk_raddr;

  logic pass_end;
  logic done_ok;
  logic res_done;
  logic key_match;
  logic lru_better;

  assign pass_end   = (cnt == CNT_END) && !rd_vld;
  assign done_ok    = !out_vld || rsp.ready;
  assign res_done   = (state == lrupfm_pkg::S_UPD) && pass_end && done_ok;
  assign key_match  = valid[rd_idx] && (key_rd == key_q);
  assign lru_better = valid[rd_idx] && (!any_v || (rank_rd > lru_rank));
  assign stk_raddr  = FB'(free_count - CW'(1));
  assign key_we     = (state == lrupfm_pkg::S_FILL);
  assign stk_we     = (state == lrupfm_pkg::S_SCAN) && pass_end && (act == lrupfm_pkg::ACT_DEL)
                      && found && (free_count != CNT_END);

  // rank rewrite for the frame coming out of the RAM
  always_comb begin
    rank_we    = 1'b0;
    rank_wdata = rank_rd;
    if ((state == lrupfm_pkg::S_UPD) && rd_vld) begin
      if (rd_idx == fsel) begin
        rank_we    = (mode != lrupfm_pkg::UPD_DEC_GT);
        rank_wdata = '0;
      end else if (valid[rd_idx]) begin
        case (mode)
          lrupfm_pkg::UPD_INC_LT: begin
            rank_we    = (rank_rd < ref_rank);
            rank_wdata = rank_rd + FB'(1);
          end
          lrupfm_pkg::UPD_DEC_GT: begin
            rank_we    = (rank_rd > ref_rank);
            rank_wdata = rank_rd - FB'(1);
          end
          lrupfm_pkg::UPD_INC_ALL: begin
            rank_we    = 1'b1;
            rank_wdata = rank_rd + FB'(1);
          end
          default: begin
            rank_we    = 1'b0;
            rank_wdata = rank_rd;
          end
        endcase
      end
    end
  end

  lrupfm_ram #(.WIDTH(KEY_BITS), .DEPTH(ENTRIES)) u_key_ram (
    .clk   (clk),
    .we    (key_we),
    .waddr (fsel),
    .wdata (key_q),
    .raddr (cnt[FB-1:0]),
    .rdata (key_rd)
  );

  lrupfm_ram #(.WIDTH(FB), .DEPTH(ENTRIES)) u_rank_ram (
    .clk   (clk),
    .we    (rank_we),
    .waddr (rd_idx),
    .wdata (rank_wdata),
    .raddr (cnt[FB-1:0]),
    .rdata (rank_rd)
  );

  lrupfm_ram #(.WIDTH(FB), .DEPTH(ENTRIES)) u_stk_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (free_count[FB-1:0]),
    .wdata (fidx),
    .raddr (stk_raddr),
    .rdata (stk_rd)
  );

  // sequencer and frame state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= lrupfm_pkg::S_IDLE;
      mode       <= lrupfm_pkg::UPD_INC_ALL;
      cnt        <= '0;
      rd_vld     <= 1'b0;
      valid      <= '0;
      dirty      <= '0;
      stk_wr     <= '0;
      free_count <= CNT_END;
      found      <= 1'b0;
      any_v      <= 1'b0;
      out_vld    <= 1'b0;
    end else begin
      rd_vld <= ((state == lrupfm_pkg::S_SCAN) || (state == lrupfm_pkg::S_UPD))
                && (cnt != CNT_END);
      rd_idx <= cnt[FB-1:0];
      if (((state == lrupfm_pkg::S_SCAN) || (state == lrupfm_pkg::S_UPD)) && (cnt != CNT_END)) begin
        cnt <= cnt + CW'(1);
      end

      if (res_done) begin
        out_vld <= 1'b1;
      end else if (rsp.ready) begin
        out_vld <= 1'b0;
      end

      case (state)
        lrupfm_pkg::S_IDLE: begin
          if (req.valid) begin
            act     <= req.action;
            key_q   <= req.page_key;
            cnt     <= '0;
            found   <= 1'b0;
            any_v   <= 1'b0;
            fsel    <= '0;
            r_hit   <= 1'b0;
            r_fetch <= 1'b0;
            r_ev    <= 1'b0;
            r_ekey  <= '0;
            r_wb    <= 1'b0;
            if ((req.action == lrupfm_pkg::ACT_GET) || (req.action == lrupfm_pkg::ACT_PUT)
                || (req.action == lrupfm_pkg::ACT_DEL)) begin
              state <= lrupfm_pkg::S_SCAN;
            end else begin
              state <= lrupfm_pkg::S_UPD;   // unused code: empty pass, zero result
              cnt   <= CNT_END;
            end
          end
        end

        lrupfm_pkg::S_SCAN: begin
          if (rd_vld) begin
            if (key_match && !found) begin
              found <= 1'b1;
              fidx  <= rd_idx;
              frank <= rank_rd;
            end
            if (lru_better) begin
              any_v    <= 1'b1;
              lru_idx  <= rd_idx;
              lru_rank <= rank_rd;
              lru_key  <= key_rd;
            end
          end
          if (pass_end) begin
            ref_rank <= frank;
            if (act == lrupfm_pkg::ACT_DEL) begin
              if (found) begin
                fsel        <= fidx;
                r_hit       <= 1'b1;
                valid[fidx] <= 1'b0;
                dirty[fidx] <= 1'b0;
                if (free_count != CNT_END) begin
                  stk_wr[free_count[FB-1:0]] <= 1'b1;
                  free_count                 <= free_count + CW'(1);
                end
                mode  <= lrupfm_pkg::UPD_DEC_GT;
                cnt   <= '0;
              end
              state <= lrupfm_pkg::S_UPD;   // delete miss: counter already at end
            end else if (found) begin
              fsel  <= fidx;
              r_hit <= 1'b1;
              if (act == lrupfm_pkg::ACT_PUT) begin
                dirty[fidx] <= 1'b1;
              end
              mode  <= lrupfm_pkg::UPD_INC_LT;
              cnt   <= '0;
              state <= lrupfm_pkg::S_UPD;
            end else if (free_count != '0) begin
              state <= lrupfm_pkg::S_POP;
            end else begin
              // all frames in use: reclaim the oldest
              fsel   <= lru_idx;
              r_ev   <= 1'b1;
              r_ekey <= lru_key;
              r_wb   <= dirty[lru_idx];
              state  <= lrupfm_pkg::S_FILL;
            end
          end
        end

        lrupfm_pkg::S_POP: begin
          pop_pos    <= stk_raddr;
          free_count <= free_count - CW'(1);
          state      <= lrupfm_pkg::S_POPW;
        end

        lrupfm_pkg::S_POPW: begin
          // never-pushed slots still hold their reset order
          fsel  <= stk_wr[pop_pos] ? stk_rd : (TOP_IDX - pop_pos);
          state <= lrupfm_pkg::S_FILL;
        end

        lrupfm_pkg::S_FILL: begin
          valid[fsel] <= 1'b1;
          dirty[fsel] <= (act == lrupfm_pkg::ACT_PUT);
          r_fetch     <= (act == lrupfm_pkg::ACT_GET);
          mode        <= lrupfm_pkg::UPD_INC_ALL;
          cnt         <= '0;
          state       <= lrupfm_pkg::S_UPD;
        end

        lrupfm_pkg::S_UPD: begin
          if (res_done) begin
            out_hit   <= r_hit;
            out_frame <= fsel;
            out_fetch <= r_fetch;
            out_ev    <= r_ev;
            out_ekey  <= r_ekey;
            out_wb    <= r_wb;
            state     <= lrupfm_pkg::S_IDLE;
          end
        end

        default: begin
          state <= lrupfm_pkg::S_IDLE;
        end
      endcase
    end
  end

  assign req.ready       = (state == lrupfm_pkg::S_IDLE);
  assign rsp.valid       = out_vld;
  assign rsp.hit         = out_hit;
  assign rsp.frame       = out_frame;
  assign rsp.fetch       = out_fetch;
  assign rsp.evicted     = out_ev;
  assign rsp.evicted_key = out_ekey;
  assign rsp.write_back  = out_wb;

  // every frame is either held or on the free stack between transactions
  `CHK_IMPLY(a_frame_account, clk, rst, state == lrupfm_pkg::S_IDLE,
             ($countones(valid) + int'(free_count)) == ENTRIES, "frame accounting broken")
  // reclaim only happens with an empty free stack
  `CHK_IMPLY(a_evict_full, clk, rst, (state == lrupfm_pkg::S_FILL) && r_ev,
             free_count == '0, "eviction with free frames left")
  // a hit never fetches or evicts
  `CHK_IMPLY(a_hit_clean, clk, rst, out_vld && out_hit,
             !out_fetch && !out_ev && !out_wb, "hit result with miss flags")
  // no reclaim means no reported key and no write back
  `CHK_IMPLY(a_no_evict_key, clk, rst, out_vld && !out_ev,
             (out_ekey == '0) && !out_wb, "evicted fields set without eviction")

endmodule

// ===== tb/sv/lru_page_frame_manager_unit_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for lru_page_frame_manager_unit: directed table, then random traffic.
// Depends on lrupfm_pkg, lrupfm_if and the RTL; predicts untyped results from its own frame table.
module lru_page_frame_manager_unit_test;

  localparam int          FRAMES       = 16;
  localparam int          RANDOM_ITEMS = 1380;
  localparam int          HOLD_CYCLES  = 400;
  localparam int          DRAIN_CYCLES = 60;
  localparam int          LIMIT        = 400000;
  localparam logic [1:0]  ACT_UNUSED   = 2'd3;

  typedef struct packed {
    logic        hit;
    logic [3:0]  frame;
    logic        fetch;
    logic        evicted;
    logic [31:0] evicted_key;
    logic        write_back;
  } page_result_t;

  typedef struct {
    logic [1:0]   act;
    logic [31:0]  key;
    bit           typed;
    page_result_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  lrupfm_req_if #(.KEY_BITS(32)) req_ch ();
  lrupfm_rsp_if #(.FRAME_BITS(4), .KEY_BITS(32)) rsp_ch ();

  lru_page_frame_manager_unit #(
    .ENTRIES (FRAMES),
    .KEY_BITS(32)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  // Frame table kept by the bench
  logic [31:0] held_key   [FRAMES];
  bit          held_valid [FRAMES];
  bit          held_dirty [FRAMES];
  int unsigned age        [FRAMES];
  int unsigned free_frames[FRAMES];
  int          free_top;

  page_result_t pending_results[$];
  stim_row_t    script[$];

  int  errors;
  int  checked;
  int  sent_count;
  int  burst_left;
  bit  gaps_on;
  int  n_hits, n_fetches, n_evictions, n_write_backs, n_freed;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void drop_age(input int slot);
    for (int i = 0; i < FRAMES; i++) begin
      if (held_valid[i] && i != slot && age[i] > age[slot]) age[i]--;
    end
    held_valid[slot] = 1'b0;
  endfunction

  function automatic page_result_t frame_table_apply(input logic [1:0] act,
                                                     input logic [31:0] key);
    page_result_t res;
    int           slot;
    bit           found;
    bit           any;
    int unsigned  oldest;
    res   = '0;
    slot  = 0;
    found = 1'b0;
    any   = 1'b0;
    oldest = 0;
    if (act != lrupfm_pkg::ACT_GET && act != lrupfm_pkg::ACT_PUT
        && act != lrupfm_pkg::ACT_DEL) return res;
    for (int i = 0; i < FRAMES; i++) begin
      if (!found && held_valid[i] && held_key[i] == key) begin
        slot  = i;
        found = 1'b1;
      end
    end
    if (act == lrupfm_pkg::ACT_DEL) begin
      if (found) begin
        drop_age(slot);
        held_dirty[slot] = 1'b0;
        if (free_top < FRAMES) begin
          free_frames[free_top] = slot;
          free_top++;
        end
        res.hit   = 1'b1;
        res.frame = 4'(slot);
      end
    end else if (found) begin
      // hit: frames more recent than this one age by one
      for (int i = 0; i < FRAMES; i++) begin
        if (held_valid[i] && i != slot && age[i] < age[slot]) age[i]++;
      end
      age[slot] = 0;
      if (act == lrupfm_pkg::ACT_PUT) held_dirty[slot] = 1'b1;
      res.hit   = 1'b1;
      res.frame = 4'(slot);
    end else begin
      if (free_top > 0) begin
        free_top--;
        slot = free_frames[free_top] % FRAMES;
      end else begin
        for (int i = 0; i < FRAMES; i++) begin
          if (held_valid[i] && (!any || age[i] > oldest)) begin
            oldest = age[i];
            slot   = i;
            any    = 1'b1;
          end
        end
        if (any) begin
          res.evicted     = 1'b1;
          res.evicted_key = held_key[slot];
          res.write_back  = held_dirty[slot];
          drop_age(slot);
        end
      end
      held_key[slot]   = key;
      held_dirty[slot] = (act == lrupfm_pkg::ACT_PUT);
      for (int i = 0; i < FRAMES; i++) begin
        if (held_valid[i] && i != slot) age[i]++;
      end
      held_valid[slot] = 1'b1;
      age[slot]        = 0;
      res.frame = 4'(slot);
      res.fetch = (act == lrupfm_pkg::ACT_GET);
    end
    return res;
  endfunction

  function automatic void add_row(input logic [1:0] act, input logic [31:0] key);
    stim_row_t row;
    row.act   = act;
    row.key   = key;
    row.typed = 1'b0;
    row.want  = '0;
    script.push_back(row);
  endfunction

  function automatic void add_typed(input logic [1:0] act, input logic [31:0] key,
                                    input bit hit, input int frame, input bit fetch,
                                    input bit evicted, input logic [31:0] ev_key,
                                    input bit wb);
    stim_row_t row;
    row.act   = act;
    row.key   = key;
    row.typed = 1'b1;
    row.want  = '{hit: hit, frame: 4'(frame), fetch: fetch, evicted: evicted,
                  evicted_key: ev_key, write_back: wb};
    script.push_back(row);
  endfunction

  function automatic string show_result(input page_result_t r);
    return $sformatf("hit=%0b frame=%0d fetch=%0b evicted=%0b evicted_key=%h write_back=%0b",
                     r.hit, r.frame, r.fetch, r.evicted, r.evicted_key, r.write_back);
  endfunction

  function automatic void flag_error(input string msg);
    errors++;
    if (errors <= 10) $display("[%0t] ERROR: %s", $realtime, msg);
  endfunction

  // One request transaction; the sender idles between bursts of requests while gaps are on.
  task automatic offer(input logic [1:0] act, input logic [31:0] key,
                       input bit typed, input page_result_t want);
    page_result_t predicted;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if (gaps_on) begin
        req_ch.valid <= 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk);
      end
    end
    burst_left--;
    req_ch.valid    <= 1'b1;
    req_ch.action   <= act;
    req_ch.page_key <= key;
    do @(posedge clk); while (!req_ch.ready);
    predicted = frame_table_apply(act, key);
    pending_results.push_back(typed ? want : predicted);
    n_hits        += predicted.hit && act != lrupfm_pkg::ACT_DEL;
    n_fetches     += predicted.fetch;
    n_evictions   += predicted.evicted;
    n_write_backs += predicted.write_back;
    n_freed       += predicted.hit && act == lrupfm_pkg::ACT_DEL;
    sent_count++;
    @(negedge clk);
  endtask

  // Receiver: rotating stall patterns plus two long hold-offs
  initial begin
    int holds_done;
    int cyc;
    int mode;
    holds_done   = 0;
    cyc          = 0;
    rsp_ch.ready = 1'b0;
    while (rst !== 1'b0) @(negedge clk);
    forever begin
      @(negedge clk);
      if (holds_done < 2 && sent_count >= 650 + 500 * holds_done) begin
        holds_done++;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      cyc++;
      mode = (cyc / 50) % 4;
      case (mode)
        0: begin
          rsp_ch.ready <= 1'b1;
        end
        1: begin
          rsp_ch.ready <= 1'($urandom_range(0, 1));
        end
        2: begin
          rsp_ch.ready <= (cyc % 4 == 0);
        end
        default: begin
          rsp_ch.ready <= ($urandom_range(0, 9) != 0);
        end
      endcase
    end
  end

  // Result checker
  always @(posedge clk) begin
    page_result_t got;
    page_result_t want;
    string        bad;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      got = '{hit: rsp_ch.hit, frame: rsp_ch.frame, fetch: rsp_ch.fetch,
              evicted: rsp_ch.evicted, evicted_key: rsp_ch.evicted_key,
              write_back: rsp_ch.write_back};
      if (pending_results.size() == 0) begin
        flag_error($sformatf("unexpected result: %s", show_result(got)));
      end else begin
        want = pending_results.pop_front();
        checked++;
        bad = "";
        if (got.hit !== want.hit) bad = {bad, " hit"};
        if (got.frame !== want.frame) bad = {bad, " frame"};
        if (got.fetch !== want.fetch) bad = {bad, " fetch"};
        if (got.evicted !== want.evicted) bad = {bad, " evicted"};
        if (got.evicted_key !== want.evicted_key) bad = {bad, " evicted_key"};
        if (got.write_back !== want.write_back) bad = {bad, " write_back"};
        if (bad != "") begin
          flag_error($sformatf("result %0d mismatch in%s\n  expected %s\n  actual   %s",
                               checked, bad, show_result(want), show_result(got)));
        end
      end
    end
  end

  // Watchdog
  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles, %0d results outstanding", LIMIT,
             pending_results.size());
    $display("Some tests failed");
    $finish;
  end

  initial begin
    logic [31:0] key_pool[32];
    int          pool_size;
    int          random_taken;
    int          pick;
    logic [1:0]  act;
    logic [31:0] key;
    rst             = 1'b1;
    req_ch.valid    = 1'b0;
    req_ch.action   = lrupfm_pkg::ACT_GET;
    req_ch.page_key = '0;
    errors = 0;  checked = 0;  sent_count = 0;  burst_left = 0;  gaps_on = 1'b1;
    n_hits = 0;  n_fetches = 0;  n_evictions = 0;  n_write_backs = 0;  n_freed = 0;
    random_taken = 0;
    pool_size    = 0;

    for (int i = 0; i < FRAMES; i++) begin
      held_key[i]    = '0;
      held_valid[i]  = 1'b0;
      held_dirty[i]  = 1'b0;
      age[i]         = 0;
      free_frames[i] = FRAMES - 1 - i;
    end
    free_top = FRAMES;

    // Directed table: empty-table misses, hit, delete miss, unused code, delete hit,
    // fill to capacity, dirty eviction of the oldest frame, clean eviction.
    add_typed(lrupfm_pkg::ACT_GET, 32'h0000_0000, 0, 0, 1, 0, 32'h0, 0);
    add_typed(lrupfm_pkg::ACT_PUT, 32'hFFFF_FFFF, 0, 1, 0, 0, 32'h0, 0);
    add_typed(lrupfm_pkg::ACT_GET, 32'hFFFF_FFFF, 1, 1, 0, 0, 32'h0, 0);
    add_typed(lrupfm_pkg::ACT_DEL, 32'h0000_1234, 0, 0, 0, 0, 32'h0, 0);
    add_typed(ACT_UNUSED,          32'hFFFF_FFFF, 0, 0, 0, 0, 32'h0, 0);
    add_typed(lrupfm_pkg::ACT_DEL, 32'h0000_0000, 1, 0, 0, 0, 32'h0, 0);
    for (int i = 0; i < 14; i++) begin
      add_row((i % 2 == 0) ? lrupfm_pkg::ACT_PUT : lrupfm_pkg::ACT_GET, 32'h8000_0000 + i);
    end
    add_row(lrupfm_pkg::ACT_GET, 32'hA5A5_A5A5);
    add_typed(lrupfm_pkg::ACT_GET, 32'h5A5A_5A5A, 0, 1, 1, 1, 32'hFFFF_FFFF, 1);
    add_row(lrupfm_pkg::ACT_PUT, 32'h8000_0000);
    add_row(lrupfm_pkg::ACT_GET, 32'h0000_0000);
    add_row(lrupfm_pkg::ACT_DEL, 32'h5A5A_5A5A);

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (script[i]) offer(script[i].act, script[i].key, script[i].typed, script[i].want);

    // Random traffic over a small key set that changes now and then, so that
    // hits, free-stack fills and evictions all occur; a few keys come from anywhere.
    while (random_taken < RANDOM_ITEMS) begin
      if (random_taken % 150 == 0 && (pool_size == 0 || act != ACT_UNUSED)) begin
        pool_size = $urandom_range(10, 30);
        for (int i = 0; i < pool_size; i++) key_pool[i] = $urandom;
      end
      gaps_on = !(random_taken >= 400 && random_taken < 600);
      pick = $urandom_range(0, 99);
      if (pick < 44)      act = lrupfm_pkg::ACT_GET;
      else if (pick < 78) act = lrupfm_pkg::ACT_PUT;
      else if (pick < 97) act = lrupfm_pkg::ACT_DEL;
      else                act = ACT_UNUSED;
      key = ($urandom_range(0, 99) < 88) ? key_pool[$urandom_range(0, pool_size - 1)]
                                          : 32'($urandom);
      offer(act, key, 1'b0, '0);
      if (act != ACT_UNUSED) random_taken++;
    end
    req_ch.valid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      flag_error($sformatf("%0d results never arrived", pending_results.size()));
    end

    $display("Ran %0d requests (%0d from the directed table): %0d hits, %0d fetches,",
             sent_count, script.size(), n_hits, n_fetches);
    $display("  %0d evictions, %0d write-backs, %0d frames freed; %0d results checked, %0d errors",
             n_evictions, n_write_backs, n_freed, checked, errors);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule
